### src/tcvs_pkg.sv
// Shared types and constants for the triangle cull and viewport setup unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package tcvs_pkg;

   // fraction bits of the Q format, default for the top level parameter
   localparam int DEF_FRAC_BITS = 16;

   // word queue between the front (cull) and the back (setup)
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // divider shape: quotient bits kept, steps per pipeline stage
   localparam int QUO_BITS  = 42;
   localparam int DIV_STEPS = 3;
   localparam int DEN_BITS  = 32;

   // configuration register indexes
   localparam logic [2:0] CSR_LEFT   = 3'd0;
   localparam logic [2:0] CSR_TOP    = 3'd1;
   localparam logic [2:0] CSR_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_CULL   = 3'd4;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [14:0]        width;
      logic [14:0]        height;
      logic               cull;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] w;
   } vtx_type;

   // v[0] is vertex a, v[1] b, v[2] c
   typedef struct packed {
      vtx_type [2:0] v;
   } tri_type;

   typedef struct packed {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [31:0] depth;
   } scr_type;

   typedef struct packed {
      scr_type [2:0] v;
      logic          fault;
   } res_type;

   // sideband that rides along the divider with each vertex
   typedef struct packed {
      logic [2:0] neg;
      logic [2:0] nz;
      logic       wz;
      logic [1:0] vidx;
   } sb_type;

endpackage

### src/tcvs_front.sv
// Front part: accepts triangles, evaluates the facing determinant, drops culled ones.
// Depends on tcvs_pkg; pushes surviving triangles into tcvs_fifo.
`timescale 1ns / 1ps

module tcvs_front import tcvs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  tri_type req_tri,
   input  logic    cull_en,
   input  logic    pop,
   output logic    push,
   output tri_type push_tri
);

   localparam int RW = $clog2(FIFO_DEPTH + 1);

   logic                   accept;
   logic                   s1_vld_ff, s2_vld_ff;
   tri_type                s1_tri_ff, s2_tri_ff;
   logic signed [63:0]     prod_ff [6];
   logic signed [64:0]     phi_ff [3];
   logic signed [64:0]     plo_ff [3];
   logic signed [99:0]     det;
   logic                   culled;
   logic [RW-1:0]          rsv_ff, rsv_in;

   assign accept = start & ~busy;
   assign busy   = (rsv_ff >= RW'(FIFO_DEPTH));

   // stage 1: the six 2x2 cofactor products of rows b and c
   always_ff @(posedge clock) begin
      logic signed [31:0] bx, by, bz, cx, cy, cz;
      bx = req_tri.v[1].x; by = req_tri.v[1].y; bz = req_tri.v[1].z;
      cx = req_tri.v[2].x; cy = req_tri.v[2].y; cz = req_tri.v[2].z;
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
      s1_tri_ff  <= req_tri;
      prod_ff[0] <= by * cz;
      prod_ff[1] <= bz * cy;
      prod_ff[2] <= bx * cz;
      prod_ff[3] <= bz * cx;
      prod_ff[4] <= bx * cy;
      prod_ff[5] <= by * cx;
   end

   // stage 2: minors times row a, split into high and low partial products
   always_ff @(posedge clock) begin
      logic signed [64:0] m [3];
      logic signed [31:0] a [3];
      logic signed [32:0] mh, ml;
      a[0] = s1_tri_ff.v[0].x;
      a[1] = s1_tri_ff.v[0].y;
      a[2] = s1_tri_ff.v[0].z;
      m[0] = 65'(prod_ff[0]) - 65'(prod_ff[1]);
      m[1] = 65'(prod_ff[2]) - 65'(prod_ff[3]);
      m[2] = 65'(prod_ff[4]) - 65'(prod_ff[5]);
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_tri_ff <= s1_tri_ff;
      for (int j = 0; j < 3; j++) begin
         mh = m[j][64:32];
         ml = $signed({1'b0, m[j][31:0]});
         phi_ff[j] <= 65'(a[j] * mh);
         plo_ff[j] <= 65'(a[j] * ml);
      end
   end

   // determinant sum and cull decision
   always_comb begin
      logic signed [99:0] t [3];
      for (int j = 0; j < 3; j++) begin
         t[j] = (100'(phi_ff[j]) <<< 32) + 100'(plo_ff[j]);
      end
      det    = t[0] - t[1] + t[2];
      culled = cull_en & ~det[99] & (det != 100'sd0);
   end

   assign push     = s2_vld_ff & ~culled;
   assign push_tri = s2_tri_ff;

   // slots reserved in the queue, counted from acceptance
   always_comb begin
      rsv_in = rsv_ff;
      if (accept) rsv_in = rsv_in + RW'(1);
      if (pop) rsv_in = rsv_in - RW'(1);
      if (s2_vld_ff & culled) rsv_in = rsv_in - RW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsv_ff <= '0;
      end else begin
         rsv_ff <= rsv_in;
      end
   end

endmodule

### src/tcvs_fifo.sv
// Short word queue between the cull front and the setup back.
// Depends on tcvs_pkg for the triangle type and depth.
`timescale 1ns / 1ps

module tcvs_fifo import tcvs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  tri_type push_tri,
   input  logic    pop,
   output logic    empty,
   output tri_type head
);

   tri_type              mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, rd_ff;
   logic [FIFO_AW:0]     cnt_ff;

   assign empty = (cnt_ff == '0);
   assign head  = mem[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_tri;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + FIFO_AW'(1);
         if (pop) rd_ff <= rd_ff + FIFO_AW'(1);
         cnt_ff <= cnt_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
      end
   end

endmodule

### src/tcvs_div.sv
// Pipelined restoring divider: several numerators over one shared denominator.
// Generic; depends on tcvs_pkg only through the import.
`timescale 1ns / 1ps

module tcvs_div import tcvs_pkg::*; #(
   parameter int NW    = 64,
   parameter int DW    = 32,
   parameter int QB    = 42,
   parameter int SPS   = 3,
   parameter int SBW   = 8,
   parameter int LANES = 3
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_vld,
   input  logic [NW-1:0]   in_num [LANES],
   input  logic [DW-1:0]   in_den,
   input  logic [SBW-1:0]  in_sb,
   output logic            out_vld,
   output logic [QB-1:0]   out_quo [LANES],
   output logic            out_ovf [LANES],
   output logic [SBW-1:0]  out_sb
);

   localparam int NSTG = QB / SPS;

   logic [DW-1:0]  rem_ff [NSTG+1][LANES];
   logic [QB-1:0]  sh_ff  [NSTG+1][LANES];
   logic           ovf_ff [NSTG+1][LANES];
   logic [DW-1:0]  den_ff [NSTG+1];
   logic [SBW-1:0] sb_ff  [NSTG+1];
   logic           vld_ff [NSTG+1];

   // entry: high numerator bits form the first remainder; too big means overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
      end
      den_ff[0] <= in_den;
      sb_ff[0]  <= in_sb;
      for (int l = 0; l < LANES; l++) begin
         rem_ff[0][l] <= DW'(in_num[l][NW-1:QB]);
         sh_ff[0][l]  <= in_num[l][QB-1:0];
         ovf_ff[0][l] <= (NW'(in_num[l][NW-1:QB]) >= NW'(in_den));
      end
   end

   // each stage retires SPS quotient bits per lane
   for (genvar s = 0; s < NSTG; s++) begin : g_stg
      logic [DW-1:0] rem_in [LANES];
      logic [QB-1:0] sh_in  [LANES];

      always_comb begin
         logic [DW:0]   t;
         logic [DW-1:0] r;
         logic [QB-1:0] q;
         for (int l = 0; l < LANES; l++) begin
            r = rem_ff[s][l];
            q = sh_ff[s][l];
            for (int k = 0; k < SPS; k++) begin
               t = {r, q[QB-1]};
               if (t >= {1'b0, den_ff[s]}) begin
                  t = t - {1'b0, den_ff[s]};
                  q = {q[QB-2:0], 1'b1};
               end else begin
                  q = {q[QB-2:0], 1'b0};
               end
               r = t[DW-1:0];
            end
            rem_in[l] = r;
            sh_in[l]  = q;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_ff[s];
         end
         den_ff[s+1] <= den_ff[s];
         sb_ff[s+1]  <= sb_ff[s];
         for (int l = 0; l < LANES; l++) begin
            rem_ff[s+1][l] <= rem_in[l];
            sh_ff[s+1][l]  <= sh_in[l];
            ovf_ff[s+1][l] <= ovf_ff[s][l];
         end
      end
   end

   assign out_vld = vld_ff[NSTG];
   assign out_sb  = sb_ff[NSTG];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = sh_ff[NSTG][l];
         out_ovf[l] = ovf_ff[NSTG][l];
      end
   end

endmodule

### src/tcvs_back.sv
// Back part: numerator setup, divider, offset add; one vertex per cycle unless empty.
// Depends on tcvs_pkg and tcvs_div; reads triangles from tcvs_fifo.
`timescale 1ns / 1ps

module tcvs_back import tcvs_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    empty,
   input  tri_type head,
   output logic    pop,
   output logic    rsp_strobe,
   output res_type rsp
);

   localparam int NW  = 48 + FRAC_BITS;
   localparam int SBW = $bits(sb_type);

   logic [1:0]          vi_ff;
   logic                issue;
   logic                pv_ff;
   logic [NW-1:0]       num_ff [3];
   logic [DEN_BITS-1:0] den_ff;
   sb_type              psb_ff;
   logic                dv;
   logic [QUO_BITS-1:0] quo [3];
   logic                ovf [3];
   logic [SBW-1:0]      dsb_raw;
   sb_type              dsb;
   logic signed [31:0]  fld [3];
   logic                vfault;
   scr_type             col_ff [2];
   logic                fault_ff;
   logic                strobe_ff;
   res_type             res_ff;

   // vertex sequencer over the queue head
   assign issue = ~empty;
   assign pop   = issue & (vi_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         vi_ff <= 2'd0;
      end else if (issue) begin
         vi_ff <= (vi_ff == 2'd2) ? 2'd0 : vi_ff + 2'd1;
      end
   end

   // numerator setup: W*|x+w|, H*|w-y|, |z|, scaled into the fraction
   always_ff @(posedge clock) begin
      vtx_type            vt;
      logic signed [32:0] sxw, swy, sz, sw;
      logic [32:0]        mx, my, mz, mw;
      logic [47:0]        nx, ny;
      vt  = head.v[vi_ff];
      sw  = 33'(vt.w);
      sxw = 33'(vt.x) + sw;
      swy = sw - 33'(vt.y);
      sz  = 33'(vt.z);
      mx  = sxw[32] ? -sxw : sxw;
      my  = swy[32] ? -swy : swy;
      mz  = sz[32] ? -sz : sz;
      mw  = sw[32] ? -sw : sw;
      nx  = 48'(cfg.width) * 48'(mx);
      ny  = 48'(cfg.height) * 48'(my);
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= issue;
      end
      num_ff[0] <= NW'(nx) << (FRAC_BITS - 1);
      num_ff[1] <= NW'(ny) << (FRAC_BITS - 1);
      num_ff[2] <= NW'(mz) << FRAC_BITS;
      den_ff    <= mw[DEN_BITS-1:0];
      psb_ff.wz   <= (vt.w == 32'sd0);
      psb_ff.vidx <= vi_ff;
      psb_ff.nz   <= {mz != '0, ny != '0, nx != '0};
      psb_ff.neg  <= (vt.w == 32'sd0) ? {sz[32], swy[32], sxw[32]}
                                      : {sz[32] ^ sw[32], swy[32] ^ sw[32], sxw[32] ^ sw[32]};
   end

   tcvs_div #(
      .NW    (NW),
      .DW    (DEN_BITS),
      .QB    (QUO_BITS),
      .SPS   (DIV_STEPS),
      .SBW   (SBW),
      .LANES (3)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (pv_ff),
      .in_num  (num_ff),
      .in_den  (den_ff),
      .in_sb   (psb_ff),
      .out_vld (dv),
      .out_quo (quo),
      .out_ovf (ovf),
      .out_sb  (dsb_raw)
   );

   assign dsb = sb_type'(dsb_raw);

   // offset add and saturation per lane
   always_comb begin
      logic signed [43:0] off [3];
      logic signed [43:0] qs, sum;
      logic               big;
      off[0] = 44'(cfg.left) <<< FRAC_BITS;
      off[1] = 44'(cfg.top) <<< FRAC_BITS;
      off[2] = '0;
      vfault = dsb.wz;
      for (int l = 0; l < 3; l++) begin
         big = dsb.wz ? dsb.nz[l]
                      : (ovf[l] | (quo[l] > QUO_BITS'(64'd1 << 40)));
         qs  = dsb.wz ? 44'sd0 : $signed({2'b00, quo[l]});
         sum = off[l] + (dsb.neg[l] ? -qs : qs);
         if (big) begin
            fld[l] = dsb.neg[l] ? 32'sh80000000 : 32'sh7FFFFFFF;
            vfault = 1'b1;
         end else if (sum > 44'sd2147483647) begin
            fld[l] = 32'sh7FFFFFFF;
            vfault = 1'b1;
         end else if (sum < -44'sd2147483648) begin
            fld[l] = 32'sh80000000;
            vfault = 1'b1;
         end else begin
            fld[l] = sum[31:0];
         end
      end
   end

   // collect the three vertices; the third one fires the result word
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dv & (dsb.vidx == 2'd2);
      end
      if (dv) begin
         case (dsb.vidx)
            2'd0: begin
               col_ff[0] <= '{sx: fld[0], sy: fld[1], depth: fld[2]};
               fault_ff  <= vfault;
            end
            2'd1: begin
               col_ff[1] <= '{sx: fld[0], sy: fld[1], depth: fld[2]};
               fault_ff  <= fault_ff | vfault;
            end
            2'd2: begin
               res_ff.v[0]  <= col_ff[0];
               res_ff.v[1]  <= col_ff[1];
               res_ff.v[2]  <= '{sx: fld[0], sy: fld[1], depth: fld[2]};
               res_ff.fault <= fault_ff | vfault;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = res_ff;

endmodule

### src/triangle_cull_viewport_setup_unit.sv
// Top level of the triangle cull and viewport setup unit.
// Depends on tcvs_pkg, tcvs_front, tcvs_fifo, tcvs_back (and tcvs_div below it).
`timescale 1ns / 1ps

// Usage
//  Request: drive req_* with one clip-space triangle (Q format, FRAC_BITS
//  fraction bits) and raise start; the word is taken at an edge where busy is
//  low. busy rises only when the four-entry queue behind the cull front is
//  fully reserved.
//  Result: rsp_strobe is high for exactly one cycle with screen x, y, depth
//  of all three vertices and divide_fault. The receiver cannot stall it.
//  Culled triangles (cull_enable set, facing away) give no result.
//  Throughput: while the queue holds a triangle, the back end takes one
//  vertex per cycle through a shared pipelined divider.
//  Path: the cull front stages, the queue write, the vertex sequencer up to
//  the third vertex, 1 setup stage, the divider stages, 1 output register.
//  Configuration: csr_we writes csr_wdata into register csr_index at once;
//  the user must write only while idle; the block does not enforce it.
//  Reset (synchronous) empties the queue and pipelines and loads left 0,
//  top 0, width 640, height 480, culling off.

module triangle_cull_viewport_setup_unit import tcvs_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_a_w,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic signed [31:0] req_b_w,
   input  logic signed [31:0] req_c_x,
   input  logic signed [31:0] req_c_y,
   input  logic signed [31:0] req_c_z,
   input  logic signed [31:0] req_c_w,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_a_sx,
   output logic signed [31:0] rsp_a_sy,
   output logic signed [31:0] rsp_a_depth,
   output logic signed [31:0] rsp_b_sx,
   output logic signed [31:0] rsp_b_sy,
   output logic signed [31:0] rsp_b_depth,
   output logic signed [31:0] rsp_c_sx,
   output logic signed [31:0] rsp_c_sy,
   output logic signed [31:0] rsp_c_depth,
   output logic               rsp_divide_fault,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   cfg_type cfg_ff;
   tri_type req_tri;
   tri_type push_tri, head;
   logic    push, pop, empty;
   res_type rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left   <= 16'sd0;
         cfg_ff.top    <= 16'sd0;
         cfg_ff.width  <= 15'd640;
         cfg_ff.height <= 15'd480;
         cfg_ff.cull   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEFT:   cfg_ff.left   <= csr_wdata;
            CSR_TOP:    cfg_ff.top    <= csr_wdata;
            CSR_WIDTH:  cfg_ff.width  <= csr_wdata[14:0];
            CSR_HEIGHT: cfg_ff.height <= csr_wdata[14:0];
            CSR_CULL:   cfg_ff.cull   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign req_tri.v[0] = '{x: req_a_x, y: req_a_y, z: req_a_z, w: req_a_w};
   assign req_tri.v[1] = '{x: req_b_x, y: req_b_y, z: req_b_z, w: req_b_w};
   assign req_tri.v[2] = '{x: req_c_x, y: req_c_y, z: req_c_z, w: req_c_w};

   tcvs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_tri  (req_tri),
      .cull_en  (cfg_ff.cull),
      .pop      (pop),
      .push     (push),
      .push_tri (push_tri)
   );

   tcvs_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_tri (push_tri),
      .pop      (pop),
      .empty    (empty),
      .head     (head)
   );

   tcvs_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   assign rsp_a_sx         = rsp.v[0].sx;
   assign rsp_a_sy         = rsp.v[0].sy;
   assign rsp_a_depth      = rsp.v[0].depth;
   assign rsp_b_sx         = rsp.v[1].sx;
   assign rsp_b_sy         = rsp.v[1].sy;
   assign rsp_b_depth      = rsp.v[1].depth;
   assign rsp_c_sx         = rsp.v[2].sx;
   assign rsp_c_sy         = rsp.v[2].sy;
   assign rsp_c_depth      = rsp.v[2].depth;
   assign rsp_divide_fault = rsp.fault;

endmodule
